// ===== rtl/ftc_pkg.sv =====
// Shared constants and register codes for the frame count to timecode converter.
// No dependencies; every other file of the block but ftc_stage_reg imports this package.
package ftc_pkg;

   // Field widths
   localparam int unsigned FC_W    = 32;  // signed frame count
   localparam int unsigned N_W     = 23;  // frame number within one day
   localparam int unsigned FPS_W   = 6;   // frame rate register
   localparam int unsigned HR_W    = 5;
   localparam int unsigned MIN_W   = 6;
   localparam int unsigned SEC_W   = 6;
   localparam int unsigned FR_W    = 6;
   localparam int unsigned SECQ_W  = 17;  // seconds within one day
   localparam int unsigned RSP_W   = 24;  // result word, padded to bytes

   // Timing constants
   localparam int unsigned SECS_PER_DAY     = 86400;
   localparam int unsigned DF_NOMINAL_FPS   = 30;
   localparam int unsigned DF_DROP          = 2;
   localparam int unsigned DF_PER_10MIN     = 17982;
   localparam int unsigned DF_PER_MINUTE    = 1798;
   localparam int unsigned DF_PER_DAY       = 2589408;
   localparam int unsigned RESET_FRAME_RATE = 25;

   // Control register indexes
   localparam int unsigned CSR_IDX_W = 1;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DROP_MODE  = 1'b0,
      CSR_FRAME_RATE = 1'b1
   } csr_index_type;

endpackage

// ===== rtl/frame_count_to_smpte_timecode.sv =====
// Converts a signed frame count into SMPTE timecode (hours, minutes, seconds,
// frames). The count is first wrapped into one 24-hour day with a true modulo,
// so negative counts land at the end of the day. In non-drop mode the rate is
// frame_rate (0 acts as 1); in drop-frame mode the rate is 29.97 at a nominal
// 30, with frame numbers 0 and 1 skipped in every minute but each tenth. The
// block is a 32-stage pipeline: 11 stages wrap the count (a restoring modulo by
// the day length, two steps per stage), 8 stages apply the drop-frame
// correction, 9 stages divide by the frame rate and 4 stages split seconds
// into seconds, minutes and hours by reciprocal multiplies. It takes one word
// per clock while results are taken; a stalled result only holds back the stages
// behind it. Control registers are to be written by the user only while no word
// is in flight; the block itself does not enforce this. csr_ready is always high.
module frame_count_to_smpte_timecode
   import ftc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request: [31:0] frame_count
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [FC_W-1:0]      req_tdata,
   // response: [4:0] hours, [10:5] minutes, [16:11] seconds,
   //           [22:17] frame_in_second, [23] zero
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,
   // control register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FPS_W-1:0]     csr_data
);

   logic             drop_mode_ff;
   logic [FPS_W-1:0] frame_rate_ff;
   logic [FPS_W-1:0] fps_ff;
   logic [FPS_W-1:0] fps_in;
   logic [N_W-1:0]   day_ff;
   logic [N_W-1:0]   day_in;
   logic [FPS_W-1:0] rate_eff;

   logic             wrap_valid;
   logic             wrap_ready;
   logic [N_W-1:0]   wrap_n;
   logic             drop_valid;
   logic             drop_ready;
   logic [N_W-1:0]   drop_n;

   logic [HR_W-1:0]  hours;
   logic [MIN_W-1:0] minutes;
   logic [SEC_W-1:0] seconds;
   logic [FR_W-1:0]  frame_in_second;

   assign csr_ready = 1'b1;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         drop_mode_ff  <= 1'b0;
         frame_rate_ff <= FPS_W'(RESET_FRAME_RATE);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DROP_MODE:  drop_mode_ff  <= csr_data[0];
            CSR_FRAME_RATE: frame_rate_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // divisor and day length, registered from the control registers
   assign rate_eff = (frame_rate_ff == '0) ? FPS_W'(1) : frame_rate_ff;
   assign fps_in   = drop_mode_ff ? FPS_W'(DF_NOMINAL_FPS) : rate_eff;
   assign day_in   = drop_mode_ff ? N_W'(DF_PER_DAY)
                                  : N_W'(rate_eff * SECS_PER_DAY);

   always_ff @(posedge clock) begin
      if (reset) begin
         fps_ff <= FPS_W'(RESET_FRAME_RATE);
         day_ff <= N_W'(RESET_FRAME_RATE * SECS_PER_DAY);
      end else begin
         fps_ff <= fps_in;
         day_ff <= day_in;
      end
   end

   ftc_wrap u_wrap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_count  (req_tdata),
      .day       (day_ff),
      .out_valid (wrap_valid),
      .out_ready (wrap_ready),
      .out_n     (wrap_n)
   );

   ftc_drop u_drop (
      .clock     (clock),
      .reset     (reset),
      .drop_mode (drop_mode_ff),
      .in_valid  (wrap_valid),
      .in_ready  (wrap_ready),
      .in_n      (wrap_n),
      .out_valid (drop_valid),
      .out_ready (drop_ready),
      .out_n     (drop_n)
   );

   ftc_split u_split (
      .clock           (clock),
      .reset           (reset),
      .fps             (fps_ff),
      .in_valid        (drop_valid),
      .in_ready        (drop_ready),
      .in_n            (drop_n),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .hours           (hours),
      .minutes         (minutes),
      .seconds         (seconds),
      .frame_in_second (frame_in_second)
   );

   // pack the result word, lowest field last
   assign rsp_tdata = {1'b0, frame_in_second, seconds, minutes, hours};

endmodule

// ===== rtl/ftc_stage_reg.sv =====
// One pipeline register with valid/ready flow control.
// Generic; used by every pipeline of the converter. No package needed.
module ftc_stage_reg #(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic             valid_ff;
   logic [WIDTH-1:0] data_ff;

   // slot may load when empty or when its word leaves this cycle
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

endmodule

// ===== rtl/ftc_wrap.sv =====
// Wraps a signed frame count into one day with a true modulo.
// Restoring modulo, two compare/subtract steps per stage; uses ftc_pkg, ftc_stage_reg.
module ftc_wrap
   import ftc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [FC_W-1:0] in_count,
   input  logic [N_W-1:0]        day,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [N_W-1:0]        out_n
);

   // day is at least 86400, so day << 16 exceeds any magnitude up to 2^31
   localparam int STEPS     = 16;
   localparam int PER       = 2;
   localparam int STEP_REGS = STEPS / PER;
   localparam int FIRST     = 2;
   localparam int NREG      = FIRST + STEP_REGS + 1;
   localparam int SH_W      = N_W + STEPS - 1;

   typedef struct packed {
      logic            neg;
      logic [FC_W-1:0] mag;
   } wrap_type;

   wrap_type        dq [0:NREG];
   logic [NREG:0]   vld;
   logic [NREG:0]   rdy;

   assign dq[0]    = '{neg: in_count[FC_W-1], mag: in_count};
   assign vld[0]   = in_valid;
   assign in_ready = rdy[0];
   assign rdy[NREG] = out_ready;
   assign out_valid = vld[NREG];
   assign out_n     = dq[NREG].mag[N_W-1:0];

   for (genvar g = 0; g < NREG; g++) begin : g_stage
      wrap_type nxt;

      if (g == 0) begin : g_cap
         // capture the raw count
         assign nxt = dq[g];
      end else if (g == 1) begin : g_abs
         // magnitude; the most negative count gives 2^31, which still fits
         always_comb begin
            nxt.neg = dq[g].neg;
            nxt.mag = dq[g].neg ? (~dq[g].mag + FC_W'(1)) : dq[g].mag;
         end
      end else if (g < FIRST + STEP_REGS) begin : g_step
         localparam int KTOP = STEPS - 1 - (g - FIRST) * PER;
         // subtract day << k where it fits
         always_comb begin
            logic [SH_W-1:0] sh;
            nxt = dq[g];
            for (int j = 0; j < PER; j++) begin
               sh = SH_W'(day) << (KTOP - j);
               if (SH_W'(nxt.mag) >= sh) begin
                  nxt.mag = nxt.mag - sh[FC_W-1:0];
               end
            end
         end
      end else begin : g_fix
         // negative count with nonzero remainder folds to day - rem
         always_comb begin
            nxt.neg = dq[g].neg;
            if (dq[g].neg && (dq[g].mag != '0)) begin
               nxt.mag = FC_W'(day) - dq[g].mag;
            end else begin
               nxt.mag = dq[g].mag;
            end
         end
      end

      ftc_stage_reg #(.WIDTH($bits(wrap_type))) u_reg (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[g]),
         .in_ready  (rdy[g]),
         .in_data   (nxt),
         .out_valid (vld[g+1]),
         .out_ready (rdy[g+1]),
         .out_data  (dq[g+1])
      );
   end

endmodule

// ===== rtl/ftc_drop.sv =====
// Drop-frame correction: adds two frame numbers per minute except every tenth.
// Splits the day count into ten-minute blocks and minutes; uses ftc_pkg, ftc_stage_reg.
module ftc_drop
   import ftc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           drop_mode,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [N_W-1:0] in_n,
   output logic           out_valid,
   input  logic           out_ready,
   output logic [N_W-1:0] out_n
);

   // blocks < 144 needs 8 quotient bits; minute index <= 9 needs 4
   localparam int BLK_W = 8;
   localparam int MIN_Q = 4;
   localparam int PER   = 2;
   localparam int NREG  = 8;

   typedef struct packed {
      logic [N_W-1:0]   n;
      logic [N_W-1:0]   rem;
      logic [BLK_W-1:0] blocks;
      logic [MIN_Q-1:0] q2;
   } drop_type;

   drop_type      dq [0:NREG];
   logic [NREG:0] vld;
   logic [NREG:0] rdy;

   assign dq[0]     = '{n: in_n, rem: in_n, blocks: '0, q2: '0};
   assign vld[0]    = in_valid;
   assign in_ready  = rdy[0];
   assign rdy[NREG] = out_ready;
   assign out_valid = vld[NREG];
   assign out_n     = dq[NREG].n;

   for (genvar g = 0; g < NREG; g++) begin : g_stage
      drop_type nxt;

      if (g < BLK_W / PER) begin : g_blk
         localparam int KTOP = BLK_W - 1 - g * PER;
         // ten-minute blocks, two quotient bits per stage
         always_comb begin
            logic [N_W-1:0] sh;
            nxt = dq[g];
            for (int j = 0; j < PER; j++) begin
               sh = N_W'(DF_PER_10MIN) << (KTOP - j);
               if (nxt.rem >= sh) begin
                  nxt.rem                = nxt.rem - sh;
                  nxt.blocks[KTOP - j]   = 1'b1;
               end
            end
         end
      end else if (g == BLK_W / PER) begin : g_off
         // skip the two frames at the head of the block, then top minute bit
         always_comb begin
            logic [N_W-1:0] sh;
            nxt = dq[g];
            nxt.rem = (dq[g].rem > N_W'(DF_DROP)) ? dq[g].rem - N_W'(DF_DROP) : '0;
            sh = N_W'(DF_PER_MINUTE) << (MIN_Q - 1);
            if (nxt.rem >= sh) begin
               nxt.rem           = nxt.rem - sh;
               nxt.q2[MIN_Q - 1] = 1'b1;
            end
         end
      end else if (g < NREG - 1) begin : g_min
         localparam int KTOP = MIN_Q - 2 - (g - BLK_W / PER - 1) * PER;
         localparam int NST  = (KTOP + 1 < PER) ? KTOP + 1 : PER;
         // minutes within the block
         always_comb begin
            logic [N_W-1:0] sh;
            nxt = dq[g];
            for (int j = 0; j < NST; j++) begin
               sh = N_W'(DF_PER_MINUTE) << (KTOP - j);
               if (nxt.rem >= sh) begin
                  nxt.rem          = nxt.rem - sh;
                  nxt.q2[KTOP - j] = 1'b1;
               end
            end
         end
      end else begin : g_sum
         // 18 numbers per block plus 2 per dropped minute
         always_comb begin
            nxt = dq[g];
            if (drop_mode) begin
               nxt.n = dq[g].n + N_W'(dq[g].blocks) * N_W'(DF_DROP * 9)
                     + N_W'(dq[g].q2) * N_W'(DF_DROP);
            end
         end
      end

      ftc_stage_reg #(.WIDTH($bits(drop_type))) u_reg (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[g]),
         .in_ready  (rdy[g]),
         .in_data   (nxt),
         .out_valid (vld[g+1]),
         .out_ready (rdy[g+1]),
         .out_data  (dq[g+1])
      );
   end

endmodule

// ===== rtl/ftc_split.sv =====
// Splits a frame number into frames, seconds, minutes and hours.
// Restoring divide by fps, then reciprocal multiplies by 60; uses ftc_pkg, ftc_stage_reg.
module ftc_split
   import ftc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [FPS_W-1:0] fps,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [N_W-1:0]   in_n,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [HR_W-1:0]  hours,
   output logic [MIN_W-1:0] minutes,
   output logic [SEC_W-1:0] seconds,
   output logic [FR_W-1:0]  frame_in_second
);

   // n < fps * 2^17 always, so 18 quotient bits cover every rate
   localparam int QW   = 18;
   localparam int PER  = 2;
   localparam int ND   = QW / PER;
   localparam int NT   = 4;
   localparam int NREG = ND + NT;

   // floor(s / 60) = (s * 139811) >> 23 for s < 86400
   localparam int               PROD_W    = 34;
   localparam int               SEC_SHIFT = 23;
   localparam logic [17:0]      SEC_RECIP = 18'd139811;
   // floor(m / 60) = (m * 2185) >> 17 for m < 1440
   localparam int               MINQ_W    = 11;
   localparam int               PROD2_W   = 22;
   localparam int               MIN_SHIFT = 17;
   localparam logic [11:0]      MIN_RECIP = 12'd2185;

   typedef struct packed {
      logic [N_W-1:0] rem;
      logic [QW-1:0]  quo;
   } div_type;

   typedef struct packed {
      logic [SECQ_W-1:0]  secs;
      logic [FR_W-1:0]    frame;
      logic [PROD_W-1:0]  prod;
      logic [MINQ_W-1:0]  mins;
      logic [SEC_W-1:0]   sec;
      logic [PROD2_W-1:0] prod2;
      logic [HR_W-1:0]    hr;
      logic [MIN_W-1:0]   mn;
   } tail_type;

   div_type       dq [0:ND];
   tail_type      tq [0:NT];
   logic [NREG:0] vld;
   logic [NREG:0] rdy;

   assign dq[0]     = '{rem: in_n, quo: '0};
   assign vld[0]    = in_valid;
   assign in_ready  = rdy[0];
   assign rdy[NREG] = out_ready;
   assign out_valid = vld[NREG];

   // divider result enters the tail
   assign tq[0] = '{secs: dq[ND].quo[SECQ_W-1:0], frame: dq[ND].rem[FR_W-1:0],
                    default: '0};

   assign hours           = tq[NT].hr;
   assign minutes         = tq[NT].mn;
   assign seconds         = tq[NT].sec;
   assign frame_in_second = tq[NT].frame;

   // divide by fps, two quotient bits per stage
   for (genvar g = 0; g < ND; g++) begin : g_div
      localparam int KTOP = QW - 1 - g * PER;
      div_type nxt;

      always_comb begin
         logic [N_W-1:0] sh;
         nxt = dq[g];
         for (int j = 0; j < PER; j++) begin
            sh = N_W'(fps) << (KTOP - j);
            if (nxt.rem >= sh) begin
               nxt.rem          = nxt.rem - sh;
               nxt.quo[KTOP - j] = 1'b1;
            end
         end
      end

      ftc_stage_reg #(.WIDTH($bits(div_type))) u_reg (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[g]),
         .in_ready  (rdy[g]),
         .in_data   (nxt),
         .out_valid (vld[g+1]),
         .out_ready (rdy[g+1]),
         .out_data  (dq[g+1])
      );
   end

   // seconds to minutes to hours
   for (genvar t = 0; t < NT; t++) begin : g_tail
      tail_type nxt;

      if (t == 0) begin : g_mul_s
         always_comb begin
            nxt      = tq[t];
            nxt.prod = PROD_W'(tq[t].secs) * PROD_W'(SEC_RECIP);
         end
      end else if (t == 1) begin : g_sec
         always_comb begin
            logic [SECQ_W-1:0] left;
            nxt      = tq[t];
            nxt.mins = tq[t].prod[SEC_SHIFT +: MINQ_W];
            left     = tq[t].secs - SECQ_W'(nxt.mins) * SECQ_W'(60);
            nxt.sec  = left[SEC_W-1:0];
         end
      end else if (t == 2) begin : g_mul_m
         always_comb begin
            nxt       = tq[t];
            nxt.prod2 = PROD2_W'(tq[t].mins) * PROD2_W'(MIN_RECIP);
         end
      end else begin : g_min
         always_comb begin
            logic [MINQ_W-1:0] left;
            nxt    = tq[t];
            nxt.hr = tq[t].prod2[MIN_SHIFT +: HR_W];
            left   = tq[t].mins - MINQ_W'(nxt.hr) * MINQ_W'(60);
            nxt.mn = left[MIN_W-1:0];
         end
      end

      ftc_stage_reg #(.WIDTH($bits(tail_type))) u_reg (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[ND+t]),
         .in_ready  (rdy[ND+t]),
         .in_data   (nxt),
         .out_valid (vld[ND+t+1]),
         .out_ready (rdy[ND+t+1]),
         .out_data  (tq[t+1])
      );
   end

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for frame_count_to_smpte_timecode: directed and random
// frame counts, predicted timecode compared word by word against the result stream.
// Depends on ftc_pkg and the converter RTL only.
module testbench;
   import ftc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
   localparam int DRAIN_CYCLES   = 40;    // pipeline is 32 deep
   localparam int MAX_GAP        = 12;
   localparam int MAX_REPORTS    = 60;
   localparam int SECS_PER_MIN   = 60;
   localparam int MINS_PER_HOUR  = 60;
   localparam int DROPS_PER_BLOCK = 9;    // dropped minutes per ten-minute block

   // result word layout, lowest field last
   typedef struct packed {
      logic             pad;
      logic [FR_W-1:0]  frames;
      logic [SEC_W-1:0] seconds;
      logic [MIN_W-1:0] minutes;
      logic [HR_W-1:0]  hours;
   } timecode_word_type;

   typedef struct {
      logic [FC_W-1:0]   count;
      timecode_word_type tc;
   } conversion_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [FC_W-1:0]      req_tdata;   // [31:0] frame_count
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_W-1:0]     rsp_tdata;   // [4:0] hours, [10:5] minutes, [16:11] seconds,
                                      // [22:17] frame_in_second, [23] zero
   logic                 csr_valid;
   logic                 csr_ready;
   csr_index_type        csr_index;
   logic [FPS_W-1:0]     csr_data;

   // shadow of the control registers
   logic                 drop_mode;
   logic [FPS_W-1:0]     rate_reg;

   conversion_type       pending_timecodes[$];
   int                   mismatches;
   int                   quiet_cycles;
   int                   stall_cycles;
   bit                   send_idle;
   bit                   recv_idle;

   frame_count_to_smpte_timecode dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Timecode for one frame count under the current register settings
   function automatic timecode_word_type predict_timecode(logic [FC_W-1:0] count);
      timecode_word_type tc;
      longint            fps;
      longint            day;
      longint            n;
      longint            blocks;
      longint            rem;
      if (drop_mode) begin
         fps = DF_NOMINAL_FPS;
         day = DF_PER_DAY;
      end else begin
         fps = (rate_reg == 0) ? 1 : longint'(rate_reg);
         day = fps * SECS_PER_DAY;
      end
      // true modulo into one day
      n = longint'($signed(count)) % day;
      if (n < 0) n = n + day;
      // drop-frame: skip two numbers per minute except every tenth
      if (drop_mode) begin
         blocks = n / longint'(DF_PER_10MIN);
         rem    = n % longint'(DF_PER_10MIN);
         if (rem > longint'(DF_DROP))
            n = n + longint'(DF_DROP) * (DROPS_PER_BLOCK * blocks
                + (rem - longint'(DF_DROP)) / longint'(DF_PER_MINUTE));
         else
            n = n + longint'(DF_DROP) * DROPS_PER_BLOCK * blocks;
      end
      tc.pad     = 1'b0;
      tc.frames  = FR_W'(n % fps);
      n          = n / fps;
      tc.seconds = SEC_W'(n % SECS_PER_MIN);
      n          = n / SECS_PER_MIN;
      tc.minutes = MIN_W'(n % MINS_PER_HOUR);
      tc.hours   = HR_W'(n / MINS_PER_HOUR);
      return tc;
   endfunction

   // Random frame count aimed at day wraps, minute edges and the 32-bit limits
   function automatic logic [FC_W-1:0] pick_frame_count();
      longint day;
      longint v;
      if (drop_mode) day = DF_PER_DAY;
      else day = ((rate_reg == 0) ? 1 : longint'(rate_reg)) * SECS_PER_DAY;
      case ($urandom_range(0, 6))
         0, 1: v = longint'($urandom);
         2: begin
            v = longint'($urandom_range(0, 40000));
            if ($urandom_range(0, 1)) v = -v;
         end
         3: v = (longint'($urandom_range(0, 1600)) - 800) * day
                + longint'($urandom_range(0, 6)) - 3;
         4: begin
            // around the start of a minute inside a ten-minute block
            v = longint'($urandom_range(0, 143)) * DF_PER_10MIN
                + longint'($urandom_range(0, 9)) * DF_PER_MINUTE
                + longint'($urandom_range(0, 5));
            if ($urandom_range(0, 1)) v = -v;
         end
         5: begin
            if ($urandom_range(0, 1)) v = 64'h7FFF_FFFF - longint'($urandom_range(0, 3));
            else v = 64'h8000_0000 + longint'($urandom_range(0, 3));
         end
         default: v = longint'($urandom);
      endcase
      return v[FC_W-1:0];
   endfunction

   function automatic int draw_gap(bit enabled);
      return enabled ? int'($urandom_range(0, MAX_GAP)) : 0;
   endfunction

   // Offer one frame count; returns at the falling edge after it was taken
   task automatic send_frame_count(logic [FC_W-1:0] count);
      int             gap;
      conversion_type item;
      gap = draw_gap(send_idle);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= count;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      item.count = count;
      item.tc    = predict_timecode(count);
      pending_timecodes.push_back(item);
      @(negedge clock);
   endtask

   // Stop offering and wait until every result is back and the pipe is empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_timecodes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [FPS_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_DROP_MODE:  drop_mode = value[0];
         CSR_FRAME_RATE: rate_reg  = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_drop_mode(logic mode);
      // upper data bits carry junk; only bit 0 matters
      write_register(CSR_DROP_MODE, {5'($urandom_range(0, 31)), mode});
   endtask

   function automatic void check_field(string name, int expected, int actual,
                                       logic [FC_W-1:0] count);
      if (expected != actual) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch for count %0d: expected %0d, actual %0d",
                     $time, name, $signed(count), expected, actual);
      end
   endfunction

   // Result side: random ready, optional long hold-off, field compare
   initial begin
      conversion_type    want;
      timecode_word_type got;
      int                gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (stall_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall_cycles) @(negedge clock);
            stall_cycles = 0;
         end
         gap = draw_gap(recv_idle);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got = timecode_word_type'(rsp_tdata);
         if (pending_timecodes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected word: expected none, actual %h", $time, rsp_tdata);
         end else begin
            want = pending_timecodes.pop_front();
            check_field("hours",   want.tc.hours,   got.hours,   want.count);
            check_field("minutes", want.tc.minutes, got.minutes, want.count);
            check_field("seconds", want.tc.seconds, got.seconds, want.count);
            check_field("frames",  want.tc.frames,  got.frames,  want.count);
            check_field("pad",     want.tc.pad,     got.pad,     want.count);
         end
         @(negedge clock);
      end
   end

   // Watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Reset values: non-drop at 25 fps, no register written yet
   task automatic test_reset_defaults();
      int counts[] = '{0, 1, -1, 25 * 86400, 32'h7FFF_FFFF, 32'h8000_0000};
      foreach (counts[i]) send_frame_count(counts[i]);
      settle();
   endtask

   // Non-drop at the rate extremes, zero rate acting as one
   task automatic test_frame_rate_extremes();
      logic [FPS_W-1:0] rates[] = '{6'd0, 6'd1, 6'd60, 6'd63};
      set_drop_mode(1'b0);
      foreach (rates[i]) begin
         write_register(CSR_FRAME_RATE, rates[i]);
         send_frame_count(-1);
         send_frame_count(32'h7FFF_FFFF);
         settle();
      end
   endtask

   // Drop-frame: skipped numbers at minute starts, tenth minutes, day wrap
   task automatic test_drop_frame_cases();
      int counts[] = '{0, 1, 2, 1799, 1800, 1801, 17981, 17982, 17983 + 1798,
                       DF_PER_DAY - 1, DF_PER_DAY, -1};
      set_drop_mode(1'b1);
      write_register(CSR_FRAME_RATE, 6'd0);  // ignored in drop mode
      foreach (counts[i]) send_frame_count(counts[i]);
      settle();
   endtask

   // Output held off for a long stretch while input keeps coming
   task automatic test_output_stall();
      set_drop_mode(1'($urandom_range(0, 1)));
      write_register(CSR_FRAME_RATE, 6'd30);
      send_idle    = 1'b0;
      stall_cycles = 300;
      repeat (120) send_frame_count(pick_frame_count());
      settle();
      send_idle = 1'b1;
   endtask

   // Random counts over a sequence of register settings
   task automatic test_random_conversions();
      logic             modes[] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
      logic [FPS_W-1:0] rates[] = '{6'd1, 6'd60, 6'd63, 6'd63, 6'd0, 6'd24};
      logic             mode;
      logic [FPS_W-1:0] rate;
      for (int phase = 0; phase < 14; phase++) begin
         if (phase < 6) begin
            mode = modes[phase];
            rate = rates[phase];
         end else begin
            mode = 1'($urandom_range(0, 1));
            rate = FPS_W'($urandom_range(0, 63));
         end
         set_drop_mode(mode);
         write_register(CSR_FRAME_RATE, rate);
         for (int i = 0; i < 100; i++) begin
            if (i % 25 == 0) begin
               // both, sender only, receiver only, or no idling
               case ($urandom_range(0, 3))
                  0: begin send_idle = 1'b1; recv_idle = 1'b1; end
                  1: begin send_idle = 1'b1; recv_idle = 1'b0; end
                  2: begin send_idle = 1'b0; recv_idle = 1'b1; end
                  default: begin send_idle = 1'b0; recv_idle = 1'b0; end
               endcase
            end
            send_frame_count(pick_frame_count());
         end
         settle();
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_DROP_MODE;
      csr_data     = '0;
      drop_mode    = 1'b0;
      rate_reg     = FPS_W'(RESET_FRAME_RATE);
      mismatches   = 0;
      stall_cycles = 0;
      send_idle    = 1'b1;
      recv_idle    = 1'b1;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_frame_rate_extremes();
      test_drop_frame_cases();
      test_output_stall();
      test_random_conversions();

      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
